// File: design/blr_pkg.sv
// ----------------------------------------------------------------------------
// blr_pkg
// Shared types and constants for the Bresenham line rasterizer.
// ----------------------------------------------------------------------------
package blr_pkg;

  localparam int COORD_W = 16;   // input endpoint field width
  localparam int SIZE_W  = 6;    // screen size register width
  localparam int PIX_W   = 10;   // reported pixel coordinate width
  localparam int SPAN_W  = 7;    // signed size minus one
  localparam int OFS_W   = 18;   // signed coordinate plus one
  localparam int PROD_W  = OFS_W + SPAN_W;

  localparam int IN_TDATA_W  = 4 * COORD_W;
  localparam int OUT_TDATA_W = 24;

  localparam logic CFG_WIDTH_IDX  = 1'b0;
  localparam logic CFG_HEIGHT_IDX = 1'b1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd63;
  // non-final results per line, end point keeps one more slot
  localparam logic [5:0]        MAX_BODY   = 6'd63;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCALE = 4'b0010,
    ST_SETUP = 4'b0100,
    ST_WALK  = 4'b1000
  } blr_state_t;

  typedef struct packed {
    logic load;    // register endpoint products
    logic scale;   // map products to screen integers
    logic setup;   // deltas, directions, error term
    logic step;    // advance one Bresenham step
    logic emit;    // load output register with the current step
  } blr_cmd_t;

  typedef struct packed {
    logic fin;        // current step is the end point
    logic emit_req;   // current step produces a result
    logic slot_free;  // output register can take a result
  } blr_status_t;

  function automatic logic signed [SPAN_W-1:0] span_of(input logic [SIZE_W-1:0] size);
    return $signed({1'b0, size}) - 7'sd1;
  endfunction

endpackage

// File: design/blr_controller.sv
// ----------------------------------------------------------------------------
// blr_controller
// Sequencer for one line: endpoint mapping, setup, then the step walk.
// ----------------------------------------------------------------------------
module blr_controller import blr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  blr_status_t status,
  output blr_cmd_t    cmd
);

  blr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        // hold the walk only when a result is due and the output is busy
        if (!status.emit_req || status.slot_free) begin
          cmd.step = !status.fin;
          cmd.emit = status.emit_req;
          if (status.fin) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_tready = (state_r == ST_IDLE);

endmodule

// File: design/blr_datapath.sv
// ----------------------------------------------------------------------------
// blr_datapath
// Screen size registers, endpoint mapping, Bresenham step registers and
// the output register.
// ----------------------------------------------------------------------------
module blr_datapath import blr_pkg::*; #(
  parameter int COORD_FRAC_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   cfg_valid,
  input  logic                   cfg_index,
  input  logic [SIZE_W-1:0]      cfg_data,
  input  blr_cmd_t               cmd,
  output blr_status_t            status,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  localparam int CW    = PROD_W - COORD_FRAC_BITS;   // screen coordinate width
  localparam int EW    = CW + 3;                     // delta and error width
  localparam int SHIFT = COORD_FRAC_BITS + 1;

  localparam logic signed [OFS_W-1:0]  ONE_Q  = OFS_W'(2**COORD_FRAC_BITS);
  localparam logic signed [PROD_W-1:0] BIAS   = PROD_W'(2**SHIFT - 1);
  localparam logic signed [CW-1:0]     PIX_LO = CW'(-512);
  localparam logic signed [CW-1:0]     PIX_HI = CW'(511);

  function automatic logic signed [PROD_W-1:0] mul_ofs(
    input logic signed [OFS_W-1:0]  v,
    input logic signed [SPAN_W-1:0] s
  );
    return PROD_W'(v) * PROD_W'(s);
  endfunction

  // divide by 2^SHIFT, truncating toward zero
  function automatic logic signed [CW-1:0] scale_down(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] b;
    b = p[PROD_W-1] ? (p + BIAS) : p;
    return CW'(b >>> SHIFT);
  endfunction

  function automatic logic [PIX_W-1:0] sat_pix(input logic signed [CW-1:0] v);
    logic [PIX_W-1:0] r;
    if (v < PIX_LO) begin
      r = 10'h200;
    end else if (v > PIX_HI) begin
      r = 10'h1ff;
    end else begin
      r = PIX_W'(v);
    end
    return r;
  endfunction

  logic [SIZE_W-1:0] width_r, height_r;
  logic              out_valid_r;

  logic signed [PROD_W-1:0] psx_r, psy_r, pex_r, pey_r;
  logic signed [CW-1:0]     cx_r, cy_r, ex_r, ey_r;
  logic signed [EW-1:0]     dx_r, dy_r, err_r;
  logic                     stx_r, sty_r;
  logic [5:0]               cnt_r;
  logic [PIX_W-1:0]         pix_x_r, pix_y_r;
  logic                     drawn_r, last_r;

  logic signed [SPAN_W-1:0] span_w, span_h;
  logic signed [OFS_W-1:0]  osx, osy, oex, oey;
  logic signed [EW-1:0]     dx_nxt, dy_nxt;
  logic signed [EW:0]       e2, ndy;
  logic                     mv_x, mv_y, on, fin;

  // configuration and output handshake state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= SIZE_RESET;
      height_r    <= SIZE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_index == CFG_WIDTH_IDX) begin
        width_r <= cfg_data;
      end
      if (cfg_valid && cfg_index == CFG_HEIGHT_IDX) begin
        height_r <= cfg_data;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // endpoint offsets, y mirrored so plus one is the top row
  always_comb begin
    span_w = span_of(width_r);
    span_h = span_of(height_r);
    osx = OFS_W'($signed(in_tdata[15:0]))  + ONE_Q;
    osy = ONE_Q - OFS_W'($signed(in_tdata[31:16]));
    oex = OFS_W'($signed(in_tdata[47:32])) + ONE_Q;
    oey = ONE_Q - OFS_W'($signed(in_tdata[63:48]));
  end

  always_comb begin
    if (ex_r > cx_r) begin
      dx_nxt = EW'(ex_r) - EW'(cx_r);
    end else begin
      dx_nxt = EW'(cx_r) - EW'(ex_r);
    end
    if (ey_r > cy_r) begin
      dy_nxt = EW'(ey_r) - EW'(cy_r);
    end else begin
      dy_nxt = EW'(cy_r) - EW'(ey_r);
    end
  end

  always_comb begin
    e2   = {err_r, 1'b0};
    ndy  = -(EW+1)'(dy_r);
    mv_x = e2 > ndy;
    mv_y = e2 < (EW+1)'(dx_r);
    on   = !cx_r[CW-1] && (cx_r < $signed({{(CW-SIZE_W){1'b0}}, width_r})) &&
           !cy_r[CW-1] && (cy_r < $signed({{(CW-SIZE_W){1'b0}}, height_r}));
    fin  = (cx_r == ex_r) && (cy_r == ey_r);
  end

  assign status.fin       = fin;
  assign status.emit_req  = fin || (on && cnt_r != MAX_BODY);
  assign status.slot_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      psx_r <= mul_ofs(osx, span_w);
      psy_r <= mul_ofs(osy, span_h);
      pex_r <= mul_ofs(oex, span_w);
      pey_r <= mul_ofs(oey, span_h);
    end
    if (cmd.scale) begin
      cx_r <= scale_down(psx_r);
      cy_r <= scale_down(psy_r);
      ex_r <= scale_down(pex_r);
      ey_r <= scale_down(pey_r);
    end
    if (cmd.setup) begin
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
      err_r <= dx_nxt - dy_nxt;
      stx_r <= cx_r < ex_r;
      sty_r <= cy_r < ey_r;
      cnt_r <= '0;
    end
    if (cmd.step) begin
      // both moves use the error value from before the step
      err_r <= err_r - (mv_x ? dy_r : '0) + (mv_y ? dx_r : '0);
      if (mv_x) begin
        cx_r <= stx_r ? cx_r + CW'(1) : cx_r - CW'(1);
      end
      if (mv_y) begin
        cy_r <= sty_r ? cy_r + CW'(1) : cy_r - CW'(1);
      end
      if (cmd.emit) begin
        cnt_r <= cnt_r + 6'd1;
      end
    end
    if (cmd.emit) begin
      pix_x_r <= sat_pix(cx_r);
      pix_y_r <= sat_pix(cy_r);
      drawn_r <= on;
      last_r  <= fin;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, drawn_r, pix_y_r, pix_x_r};
  assign out_tlast  = last_r;

endmodule

// File: design/bresenham_line_raster_top.sv
// ----------------------------------------------------------------------------
// bresenham_line_raster_top
// Maps a normalized line segment to screen integers and walks the Bresenham
// line, one result transaction per on-screen step (at most 63) plus the end point.
// ----------------------------------------------------------------------------
// after an input transaction the sequencer passes through SCALE and SETUP, then the
// walk loop registers results and advances one step per cycle, except while a
//   result waits on out_tready
// a new line is taken only after the end point result is in the output register
// reset: rst_n synchronous, clears the sequencer and output valid and sets
//   both screen size registers to 63
module bresenham_line_raster_top import blr_pkg::*; #(
  parameter int COORD_FRAC_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // start_x[15:0], start_y[31:16], end_x[47:32], end_y[63:48]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // pixel_x[9:0], pixel_y[19:10], drawn[20], zero fill[23:21]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [SIZE_W-1:0]      cfg_data
);

  blr_cmd_t    cmd;
  blr_status_t status;

  assign cfg_ready = 1'b1;

  blr_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  blr_datapath #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// File: design/blr_checker.sv
// ----------------------------------------------------------------------------
// blr_checker
// Port-level checks on the line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module blr_checker import blr_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // one line at a time: in_tready drops right after a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted during a line");

  // only the end point may be reported off screen
  a_undrawn_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[20])
    else $error("off-screen step reported before the end point");

  // drawn pixels have non-negative coordinates
  a_drawn_positive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[20] |-> !out_tdata[9] && !out_tdata[19])
    else $error("drawn pixel with negative coordinate");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("not idle after reset");

endmodule

bind bresenham_line_raster_top blr_checker u_blr_checker (.*);

// File: test/tb_bresenham_line_raster_top.sv
// ----------------------------------------------------------------------------
// tb_bresenham_line_raster_top
// Streams line segments into the rasterizer and compares every pixel
// transaction against a Bresenham walk computed in the bench. The screen size
// is changed between phases while idle; each stream side idles at random in the phases that enable it.
// ----------------------------------------------------------------------------
module tb_bresenham_line_raster_top;
  import blr_pkg::*;

  localparam int FRAC_BITS   = 12;
  localparam int MAX_PIXELS  = 64;
  localparam int WDOG_LIMIT  = 8000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic signed [COORD_W-1:0] ey;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] sx;
  } line_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] x;
    logic signed [PIX_W-1:0] y;
    logic                    drawn;
    logic                    last;
  } pixel_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic                   cfg_index = CFG_WIDTH_IDX;
  logic [SIZE_W-1:0]      cfg_data = '0;

  line_t       line_q[$];
  pixel_t      pixel_q[$];
  logic [5:0]  scr_w = SIZE_RESET;
  logic [5:0]  scr_h = SIZE_RESET;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  int          err_cnt = 0;
  int          tx_wait;
  int          rx_wait;
  int          rx_draw;
  int          hold_left;
  int          holds_done;
  int          results_seen;
  int          quiet_cycles = 0;

  bresenham_line_raster_top #(.COORD_FRAC_BITS(FRAC_BITS)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // normalized coordinate to screen integer, truncating toward zero
  function automatic longint to_screen(input longint v, input logic [5:0] size);
    longint span;
    span = longint'(size) - 1;
    return ((v + (longint'(1) << FRAC_BITS)) * span) / (longint'(1) << (FRAC_BITS + 1));
  endfunction

  function automatic logic [PIX_W-1:0] clamp10(input longint v);
    if (v < -512) return 10'h200;
    if (v > 511) return 10'h1ff;
    return v[PIX_W-1:0];
  endfunction

  // walk the line and queue the pixels it should produce
  task automatic rasterize(input line_t ln);
    longint w, h, cx, cy, tx, ty, dx, dy, stx, sty, err, e2;
    int     n;
    bit     on, done;
    pixel_t px;
    w = longint'(scr_w);
    h = longint'(scr_h);
    cx = to_screen(longint'(ln.sx), scr_w);
    cy = to_screen(-longint'(ln.sy), scr_h);
    tx = to_screen(longint'(ln.ex), scr_w);
    ty = to_screen(-longint'(ln.ey), scr_h);
    dx = tx > cx ? tx - cx : cx - tx;
    dy = ty > cy ? ty - cy : cy - ty;
    stx = cx < tx ? 1 : -1;
    sty = cy < ty ? 1 : -1;
    err = dx - dy;
    n = 0;
    done = 1'b0;
    while (!done) begin
      on = cx >= 0 && cx < w && cy >= 0 && cy < h;
      px.x = clamp10(cx);
      px.y = clamp10(cy);
      px.drawn = on;
      if (cx == tx && cy == ty) begin
        px.last = 1'b1;
        pixel_q.push_back(px);
        done = 1'b1;
      end else begin
        // one slot is always kept for the end point
        if (on && n < MAX_PIXELS - 1) begin
          px.last = 1'b0;
          pixel_q.push_back(px);
          n++;
        end
        e2 = err * 2;
        if (e2 > -dy) begin
          err -= dy;
          cx += stx;
        end
        if (e2 < dx) begin
          err += dx;
          cy += sty;
        end
      end
    end
  endtask

  task automatic mismatch(input string fld, input int exp_val, input int act_val);
    err_cnt++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, fld, exp_val, act_val);
  endtask

  // driver: one line transaction at a time from line_q
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      tx_wait <= 0;
    end else begin
      if (in_tvalid && in_tready)
        rasterize(line_t'(in_tdata));
      if (!in_tvalid || in_tready) begin
        if (tx_wait != 0) begin
          tx_wait <= tx_wait - 1;
          in_tvalid <= 1'b0;
        end else if (line_q.size() != 0) begin
          in_tdata <= line_q.pop_front();
          in_tvalid <= 1'b1;
          tx_wait <= tx_idle_en ? int'($urandom_range(0, 4)) : 0;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks pixels and drives out_tready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait <= 0;
      hold_left <= 0;
      holds_done <= 0;
      results_seen <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        if (pixel_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected pixel transaction, expected none, got data %h last %b",
                   $time, out_tdata, out_tlast);
        end else begin
          pixel_t want;
          want = pixel_q.pop_front();
          if (out_tdata[9:0] !== want.x)
            mismatch("pixel_x", want.x, $signed(out_tdata[9:0]));
          if (out_tdata[19:10] !== want.y)
            mismatch("pixel_y", want.y, $signed(out_tdata[19:10]));
          if (out_tdata[20] !== want.drawn)
            mismatch("drawn", want.drawn, out_tdata[20]);
          if (out_tlast !== want.last)
            mismatch("last", want.last, out_tlast);
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (holds_done < 2 && in_tvalid && !in_tready &&
                   results_seen > (holds_done == 0 ? 50 : 3000)) begin
        // long back-pressure while the sender keeps offering lines
        hold_left <= HOLD_CYCLES;
        holds_done <= holds_done + 1;
        out_tready <= 1'b0;
      end else if (out_tvalid && out_tready) begin
        rx_draw = rx_idle_en ? int'($urandom_range(0, 4)) : 0;
        rx_wait <= rx_draw;
        out_tready <= (rx_draw == 0);
      end else if (rx_wait != 0) begin
        rx_wait <= rx_wait - 1;
        out_tready <= (rx_wait == 1);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // wait until every queued line is sent and every pixel has come back
  task automatic drain();
    while (line_q.size() != 0 || in_tvalid || pixel_q.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [5:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_WIDTH_IDX) scr_w = val;
    else scr_h = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_coord(input int unsigned kind);
    case (kind)
      0: return 16'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'hf000;
          3: return 16'h1000;
          default: return 16'h0000;
        endcase
      end
      default: return 16'($urandom_range(0, 12000) - 6000);
    endcase
  endfunction

  task automatic push_lines(input int count);
    line_t       ln;
    int unsigned kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 19);
      if (kind < 12) kind = 2;
      else if (kind < 15) kind = 0;
      else if (kind < 17) kind = 3;
      else kind = 1;
      ln.sx = pick_coord(kind == 3 ? $urandom_range(0, 2) : kind);
      ln.sy = pick_coord(kind == 3 ? $urandom_range(0, 2) : kind);
      ln.ex = pick_coord(kind);
      ln.ey = pick_coord(kind);
      // degenerate: end point equals start point
      if (kind == 3) begin
        ln.ex = ln.sx;
        ln.ey = ln.sy;
      end
      line_q.push_back(ln);
      // sender pause mid-phase until the block has emptied
      if (i == count / 2) drain();
    end
  endtask

  task automatic push_line(input int sx, input int sy, input int ex, input int ey);
    line_t ln;
    ln.sx = 16'(sx);
    ln.sy = 16'(sy);
    ln.ex = 16'(ex);
    ln.ey = 16'(ey);
    line_q.push_back(ln);
  endtask

  task automatic run_phase(input logic [5:0] w, input logic [5:0] h, input int count,
                           input bit tx_idle, input bit rx_idle);
    drain();
    write_reg(CFG_WIDTH_IDX, w);
    write_reg(CFG_HEIGHT_IDX, h);
    tx_idle_en = tx_idle;
    rx_idle_en = rx_idle;
    push_lines(count);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed lines at the reset screen size
    push_line(0, 0, 0, 0);
    push_line(-4096, 4096, 4096, -4096);
    push_line(4096, -4096, -4096, 4096);
    push_line(-4096, 0, 4096, 0);
    push_line(0, 4096, 0, -4096);
    push_line(-32768, -32768, 32767, 32767);
    push_line(32767, 32767, -32768, -32768);
    push_line(-32768, 0, 32767, 0);
    push_line(32767, 32767, 32767, 32767);
    push_line(-32768, 32767, -32768, 32767);
    push_line(-20000, -20000, -18000, -30000);
    push_line(0, 0, 30000, 0);
    push_line(30000, 1000, 0, 0);
    push_line(-4096, -4096, 4096, -2000);
    push_line(-1000, 4096, 1000, -4096);
    push_line(4095, 4095, 4096, 4096);
    push_line(-1, 1, 1, -1);
    push_line(-4097, 4097, -4095, 4095);
    push_line(-8192, 0, 8192, 0);
    push_lines(60);

    run_phase(6'd1, 6'd1, 50, 1'b1, 1'b1);
    run_phase(6'd0, 6'd0, 40, 1'b0, 1'b0);
    run_phase(6'd63, 6'd1, 50, 1'b1, 1'b1);
    run_phase(6'd1, 6'd63, 50, 1'b1, 1'b0);
    run_phase(6'd17, 6'd40, 60, 1'b0, 1'b1);
    run_phase(6'($urandom), 6'($urandom), 60, 1'b1, 1'b1);
    run_phase(6'd63, 6'd63, 70, 1'b0, 1'b0);

    drain();
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
design/blr_pkg.sv
design/blr_controller.sv
design/blr_datapath.sv
design/bresenham_line_raster_top.sv
design/blr_checker.sv
test/tb_bresenham_line_raster_top.sv
